// File: rtl/lkr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkr_pkg - shared definitions for the LRU-K frame replacer
// Port field types, request and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package lkr_pkg;

   // parameter defaults
   localparam int DEF_FRAME_COUNT = 64;
   localparam int DEF_MAX_K       = 8;
   localparam int DEF_TIME_BITS   = 48;

   // port field types
   typedef logic [1:0] mode_type;
   typedef logic [7:0] frame_type;
   typedef logic [2:0] status_type;
   typedef logic [5:0] victim_type;
   typedef logic [6:0] count_type;
   typedef logic [3:0] depth_type;

   // history depth after reset
   localparam depth_type HIST_DEPTH_RESET = 4'd2;

   // request codes
   localparam mode_type MODE_ACCESS = 2'd0;
   localparam mode_type MODE_MARK   = 2'd1;
   localparam mode_type MODE_REMOVE = 2'd2;
   localparam mode_type MODE_EVICT  = 2'd3;

   // status codes
   localparam status_type STAT_OK        = 3'd0;
   localparam status_type STAT_NO_VICTIM = 3'd1;
   localparam status_type STAT_RANGE     = 3'd2;
   localparam status_type STAT_PINNED    = 3'd3;
   localparam status_type STAT_UNTRACKED = 3'd4;

endpackage
`default_nettype wire

// File: rtl/lkr_hist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkr_hist - access history store
// Per-frame ring metadata (access count, oldest slot) and the ring of access
// times, each a single-port-write, single-port-read memory with registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module lkr_hist #(
   parameter int FRAME_COUNT = lkr_pkg::DEF_FRAME_COUNT,
   parameter int MAX_K       = lkr_pkg::DEF_MAX_K,
   parameter int TIME_BITS   = lkr_pkg::DEF_TIME_BITS,
   parameter int FW          = $clog2(FRAME_COUNT),
   parameter int MW          = $clog2(MAX_K + 1) + ((MAX_K > 1) ? $clog2(MAX_K) : 1),
   parameter int AW          = $clog2(FRAME_COUNT * MAX_K)
) (
   input  logic                 clock,
   // metadata port
   input  logic [FW-1:0]        meta_rd_addr,
   output logic [MW-1:0]        meta_rd_data,
   input  logic                 meta_wr_en,
   input  logic [FW-1:0]        meta_wr_addr,
   input  logic [MW-1:0]        meta_wr_data,
   // access time port
   input  logic [AW-1:0]        time_rd_addr,
   output logic [TIME_BITS-1:0] time_rd_data,
   input  logic                 time_wr_en,
   input  logic [AW-1:0]        time_wr_addr,
   input  logic [TIME_BITS-1:0] time_wr_data
);
   import lkr_pkg::*;

   localparam int TD = FRAME_COUNT * MAX_K;

   logic [MW-1:0]        meta_mem [FRAME_COUNT];
   logic [TIME_BITS-1:0] time_mem [TD];
   logic [MW-1:0]        meta_rd_ff;
   logic [TIME_BITS-1:0] time_rd_ff;

   // metadata memory
   always_ff @(posedge clock) begin
      if (meta_wr_en) begin
         meta_mem[meta_wr_addr] <= meta_wr_data;
      end
      meta_rd_ff <= meta_mem[meta_rd_addr];
   end

   // access time memory
   always_ff @(posedge clock) begin
      if (time_wr_en) begin
         time_mem[time_wr_addr] <= time_wr_data;
      end
      time_rd_ff <= time_mem[time_rd_addr];
   end

   assign meta_rd_data = meta_rd_ff;
   assign time_rd_data = time_rd_ff;

endmodule
`default_nettype wire

// File: rtl/lru_k_frame_replacer.sv
`default_nettype none
// Record access, set mark and remove: registered, run in the execute state and their result
// registered from the finish state. Evict: the execute state starts the scan, one frame per
// cycle through the history memory read port and one shared subtract-and-compare unit, then
// commit and finish. A request is taken only in idle; a result held on the output keeps the
// next one in finish. Reset (synchronous) clears presence, marks, the evictable count and the
// clock and sets k to 2; the history memories are not cleared, so there is no start-up pass.
// ----------------------------------------------------------------------------
// lru_k_frame_replacer - LRU-K buffer frame replacer
// Tracks per-frame presence, evictable mark and the last MAX_K access times,
// and picks the evictable frame with the largest backward k-distance.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer #(
   parameter int FRAME_COUNT = lkr_pkg::DEF_FRAME_COUNT,
   parameter int MAX_K       = lkr_pkg::DEF_MAX_K,
   parameter int TIME_BITS   = lkr_pkg::DEF_TIME_BITS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  lkr_pkg::mode_type   req_mode,
   input  lkr_pkg::frame_type  req_frame,
   input  logic                req_evictable,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lkr_pkg::status_type rsp_status,
   output lkr_pkg::victim_type rsp_victim_frame,
   output lkr_pkg::count_type  rsp_evictable_count,
   // configuration
   input  logic                csr_wr_en,
   input  lkr_pkg::depth_type  csr_wr_data
);
   import lkr_pkg::*;

   localparam int FW = $clog2(FRAME_COUNT);
   localparam int IW = FW + 1;
   localparam int NW = $clog2(FRAME_COUNT + 1);
   localparam int CW = $clog2(MAX_K + 1);
   localparam int OW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int SW = CW + 1;
   localparam int MW = CW + OW;
   localparam int AW = $clog2(FRAME_COUNT * MAX_K);

   localparam logic [AW-1:0] K_STRIDE  = AW'(MAX_K);
   localparam logic [CW-1:0] K_MAX     = CW'(MAX_K);
   localparam logic [SW-1:0] K_WRAP    = SW'(MAX_K);
   localparam logic [OW-1:0] SLOT_LAST = OW'(MAX_K - 1);
   localparam logic [FW-1:0] LAST_IDX  = FW'(FRAME_COUNT - 1);
   localparam logic [IW-1:0] SCAN_END  = IW'(FRAME_COUNT);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_FIN    = 3'd4;

   // control registers
   logic [2:0]             state_ff,    state_in;
   depth_type              hdepth_ff,   hdepth_in;
   logic [TIME_BITS-1:0]   now_ff,      now_in;
   logic [FRAME_COUNT-1:0] tracked_ff,  tracked_in;
   logic [FRAME_COUNT-1:0] evict_ff,    evict_in;
   logic [NW-1:0]          total_ff,    total_in;
   logic [IW-1:0]          issue_ff,    issue_in;
   logic                   p1_valid_ff, p1_valid_in;
   logic                   p2_valid_ff, p2_valid_in;
   logic                   best_found_ff, best_found_in;
   logic                   rsp_valid_ff,  rsp_valid_in;

   // payload registers
   mode_type              mode_ff,     mode_in;
   frame_type             frame_ff,    frame_in;
   logic                  ev_ff,       ev_in;
   logic [FW-1:0]         p1_idx_ff,   p1_idx_in;
   logic                  p1_elig_ff,  p1_elig_in;
   logic [FW-1:0]         p2_idx_ff,   p2_idx_in;
   logic                  p2_elig_ff,  p2_elig_in;
   logic                  p2_inf_ff,   p2_inf_in;
   logic                  best_inf_ff, best_inf_in;
   logic [TIME_BITS-1:0]  best_val_ff, best_val_in;
   logic [FW-1:0]         best_idx_ff, best_idx_in;
   status_type            res_status_ff, res_status_in;
   logic [FW-1:0]         res_victim_ff, res_victim_in;
   status_type            rsp_status_ff, rsp_status_in;
   victim_type            rsp_victim_ff, rsp_victim_in;
   count_type             rsp_count_ff,  rsp_count_in;

   // history store ports
   logic [FW-1:0]         meta_rd_addr;
   logic [MW-1:0]         meta_rd_data;
   logic                  meta_wr_en;
   logic [MW-1:0]         meta_wr_data;
   logic [AW-1:0]         time_rd_addr;
   logic [TIME_BITS-1:0]  time_rd_data;
   logic                  time_wr_en;
   logic [AW-1:0]         time_wr_addr;

   // decoded request and helpers
   logic                  req_beat;
   logic                  in_range;
   logic [FW-1:0]         fidx;
   logic [CW-1:0]         k_eff;
   logic [CW-1:0]         rd_cnt;
   logic [OW-1:0]         rd_old;
   logic [CW-1:0]         base_cnt;
   logic [OW-1:0]         base_old;
   logic [SW-1:0]         push_sum;
   logic [OW-1:0]         push_slot;
   logic [CW-1:0]         push_cnt;
   logic [OW-1:0]         push_old;
   logic                  scan_inf;
   logic [SW-1:0]         scan_sum;
   logic [OW-1:0]         scan_slot;
   logic [TIME_BITS-1:0]  scan_val;
   logic                  scan_better;
   logic                  rsp_free;

   lkr_hist #(
      .FRAME_COUNT (FRAME_COUNT),
      .MAX_K       (MAX_K),
      .TIME_BITS   (TIME_BITS),
      .FW          (FW),
      .MW          (MW),
      .AW          (AW)
   ) u_hist (
      .clock        (clock),
      .meta_rd_addr (meta_rd_addr),
      .meta_rd_data (meta_rd_data),
      .meta_wr_en   (meta_wr_en),
      .meta_wr_addr (fidx),
      .meta_wr_data (meta_wr_data),
      .time_rd_addr (time_rd_addr),
      .time_rd_data (time_rd_data),
      .time_wr_en   (time_wr_en),
      .time_wr_addr (time_wr_addr),
      .time_wr_data (now_ff)
   );

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign in_range = ({1'b0, frame_ff} < 9'(FRAME_COUNT));
   assign fidx     = frame_ff[FW-1:0];

   // effective k: zero acts as one, above MAX_K clamps
   always_comb begin
      if (hdepth_ff == '0) begin
         k_eff = CW'(1);
      end else if ({1'b0, hdepth_ff} > 5'(MAX_K)) begin
         k_eff = K_MAX;
      end else begin
         k_eff = CW'(hdepth_ff);
      end
   end

   assign rd_cnt = meta_rd_data[MW-1:OW];
   assign rd_old = meta_rd_data[OW-1:0];

   // record access: ring push for the requested frame
   always_comb begin
      base_cnt = tracked_ff[fidx] ? rd_cnt : '0;
      base_old = tracked_ff[fidx] ? rd_old : '0;
      push_sum = SW'(base_old) + SW'(base_cnt);
      if (base_cnt < K_MAX) begin
         push_slot = (push_sum >= K_WRAP) ? OW'(push_sum - K_WRAP) : OW'(push_sum);
         push_cnt  = base_cnt + CW'(1);
         push_old  = base_old;
      end else begin
         push_slot = base_old;
         push_cnt  = base_cnt;
         push_old  = (base_old == SLOT_LAST) ? '0 : base_old + OW'(1);
      end
   end

   assign meta_wr_en   = (state_ff == ST_EXEC) && (mode_ff == MODE_ACCESS) && in_range;
   assign time_wr_en   = meta_wr_en;
   assign meta_wr_data = {push_cnt, push_old};
   assign time_wr_addr = AW'(fidx) * K_STRIDE + AW'(push_slot);

   // scan stage 1: pick the k-th most recent slot
   always_comb begin
      scan_inf  = (rd_cnt < k_eff);
      scan_sum  = SW'(rd_old) + SW'(rd_cnt - k_eff);
      if (scan_inf) begin
         scan_slot = rd_old;
      end else if (scan_sum >= K_WRAP) begin
         scan_slot = OW'(scan_sum - K_WRAP);
      end else begin
         scan_slot = OW'(scan_sum);
      end
   end

   assign meta_rd_addr = (state_ff == ST_SCAN) ? issue_ff[FW-1:0] : req_frame[FW-1:0];
   assign time_rd_addr = AW'(p1_idx_ff) * K_STRIDE + AW'(scan_slot);

   // scan stage 2: shared distance and compare unit
   assign scan_val    = now_ff - time_rd_data;
   assign scan_better = !best_found_ff || (p2_inf_ff && !best_inf_ff) ||
                        ((p2_inf_ff == best_inf_ff) && (scan_val > best_val_ff));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      hdepth_in     = csr_wr_en ? csr_wr_data : hdepth_ff;
      now_in        = now_ff;
      tracked_in    = tracked_ff;
      evict_in      = evict_ff;
      total_in      = total_ff;
      issue_in      = issue_ff;
      p1_valid_in   = 1'b0;
      p1_idx_in     = issue_ff[FW-1:0];
      p1_elig_in    = tracked_ff[issue_ff[FW-1:0]] && evict_ff[issue_ff[FW-1:0]];
      p2_valid_in   = p1_valid_ff;
      p2_idx_in     = p1_idx_ff;
      p2_elig_in    = p1_elig_ff;
      p2_inf_in     = scan_inf;
      best_found_in = best_found_ff;
      best_inf_in   = best_inf_ff;
      best_val_in   = best_val_ff;
      best_idx_in   = best_idx_ff;
      mode_in       = mode_ff;
      frame_in      = frame_ff;
      ev_in         = ev_ff;
      res_status_in = res_status_ff;
      res_victim_in = res_victim_ff;
      rsp_status_in = rsp_status_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_stall ? rsp_valid_ff : 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               mode_in  = req_mode;
               frame_in = req_frame;
               ev_in    = req_evictable;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_status_in = STAT_OK;
            res_victim_in = '0;
            state_in      = ST_FIN;
            if ((mode_ff != MODE_EVICT) && !in_range) begin
               res_status_in = STAT_RANGE;
            end else begin
               unique case (mode_ff)
                  MODE_ACCESS: begin
                     tracked_in[fidx] = 1'b1;
                     now_in           = now_ff + TIME_BITS'(1);
                  end
                  MODE_MARK: begin
                     if (!tracked_ff[fidx]) begin
                        res_status_in = STAT_UNTRACKED;
                     end else if (evict_ff[fidx] && !ev_ff) begin
                        evict_in[fidx] = 1'b0;
                        total_in       = total_ff - NW'(1);
                     end else if (!evict_ff[fidx] && ev_ff) begin
                        evict_in[fidx] = 1'b1;
                        total_in       = total_ff + NW'(1);
                     end
                  end
                  MODE_REMOVE: begin
                     if (!tracked_ff[fidx]) begin
                        res_status_in = STAT_UNTRACKED;
                     end else if (!evict_ff[fidx]) begin
                        res_status_in = STAT_PINNED;
                     end else begin
                        tracked_in[fidx] = 1'b0;
                        evict_in[fidx]   = 1'b0;
                        total_in         = total_ff - NW'(1);
                     end
                  end
                  default: begin
                     // evict: start the frame scan
                     issue_in      = '0;
                     best_found_in = 1'b0;
                     p2_valid_in   = 1'b0;
                     state_in      = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_ff < SCAN_END) begin
               p1_valid_in = 1'b1;
               issue_in    = issue_ff + IW'(1);
            end
            if (p2_valid_ff && p2_elig_ff && scan_better) begin
               best_found_in = 1'b1;
               best_inf_in   = p2_inf_ff;
               best_val_in   = scan_val;
               best_idx_in   = p2_idx_ff;
            end
            if (p2_valid_ff && (p2_idx_ff == LAST_IDX)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_FIN;
            if (best_found_ff) begin
               tracked_in[best_idx_ff] = 1'b0;
               evict_in[best_idx_ff]   = 1'b0;
               total_in                = total_ff - NW'(1);
               res_status_in           = STAT_OK;
               res_victim_in           = best_idx_ff;
            end else begin
               res_status_in = STAT_NO_VICTIM;
               res_victim_in = '0;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_victim_in = 6'(res_victim_ff);
               rsp_count_in  = 7'(total_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hdepth_ff     <= HIST_DEPTH_RESET;
         now_ff        <= '0;
         tracked_ff    <= '0;
         evict_ff      <= '0;
         total_ff      <= '0;
         issue_ff      <= '0;
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hdepth_ff     <= hdepth_in;
         now_ff        <= now_in;
         tracked_ff    <= tracked_in;
         evict_ff      <= evict_in;
         total_ff      <= total_in;
         issue_ff      <= issue_in;
         p1_valid_ff   <= p1_valid_in;
         p2_valid_ff   <= p2_valid_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      frame_ff      <= frame_in;
      ev_ff         <= ev_in;
      p1_idx_ff     <= p1_idx_in;
      p1_elig_ff    <= p1_elig_in;
      p2_idx_ff     <= p2_idx_in;
      p2_elig_ff    <= p2_elig_in;
      p2_inf_ff     <= p2_inf_in;
      best_inf_ff   <= best_inf_in;
      best_val_ff   <= best_val_in;
      best_idx_ff   <= best_idx_in;
      res_status_ff <= res_status_in;
      res_victim_ff <= res_victim_in;
      rsp_status_ff <= rsp_status_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_victim_frame    = rsp_victim_ff;
   assign rsp_evictable_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   // the evictable count matches the marks held
   a_total_matches: assert property (@(posedge clock) disable iff (reset)
      total_ff == NW'($countones(evict_ff)))
      else $error("evictable count out of step with marks");

   // only tracked frames can carry an evictable mark
   a_mark_tracked: assert property (@(posedge clock) disable iff (reset)
      (evict_ff & ~tracked_ff) == '0)
      else $error("evictable mark on untracked frame");

   // a chosen victim is still evictable when committed
   a_victim_evictable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) && best_found_ff |-> evict_ff[best_idx_ff])
      else $error("victim not evictable at commit");

   // the clock only moves on a recorded access
   a_clock_access: assert property (@(posedge clock) disable iff (reset)
      !((state_ff == ST_EXEC) && (mode_ff == MODE_ACCESS) && in_range) |=> $stable(now_ff))
      else $error("clock advanced without an access");
`endif

endmodule
`default_nettype wire

// File: dv/lru_k_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_k_checker - response checker for the LRU-K frame replacer
// Watches the request, response and register ports, keeps its own copy of
// the replacer state, works out the response owed for every request beat and
// compares each response beat field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module lru_k_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  lkr_pkg::mode_type   req_mode,
   input  lkr_pkg::frame_type  req_frame,
   input  logic                req_evictable,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  lkr_pkg::status_type rsp_status,
   input  lkr_pkg::victim_type rsp_victim_frame,
   input  lkr_pkg::count_type  rsp_evictable_count,
   input  logic                csr_wr_en,
   input  lkr_pkg::depth_type  csr_wr_data,
   output int                  fail_count,
   output int                  outstanding
);
   import lkr_pkg::*;

   localparam int FRAMES     = DEF_FRAME_COUNT;
   localparam int HIST       = DEF_MAX_K;
   localparam int TBITS      = DEF_TIME_BITS;
   localparam int OWED_DEPTH = 16;

   typedef logic [TBITS-1:0] stamp_type;

   typedef struct packed {
      status_type status;
      victim_type victim;
      count_type  count;
   } rsp_beat_type;

   // shadow of the replacer state
   logic        present  [FRAMES];
   logic        evict_ok [FRAMES];
   stamp_type   hist     [FRAMES][HIST];
   int unsigned hits     [FRAMES];
   int unsigned head     [FRAMES];
   stamp_type   now_stamp;
   int unsigned evict_total;
   depth_type   k_reg;

   // ring of responses owed, oldest at owed_rd
   rsp_beat_type owed_buf [OWED_DEPTH];
   int unsigned  owed_rd;
   int unsigned  owed_wr;
   int           mismatches;

   assign fail_count = mismatches;

   // one request against the shadow state; returns the response it owes
   function automatic rsp_beat_type serve_request(mode_type m, frame_type f, logic ev);
      rsp_beat_type r;
      int unsigned  k, cnt, slot, best;
      bit           found, best_inf, inf;
      stamp_type    age, best_age;
      r = '0;
      if (m != MODE_EVICT && f >= FRAMES) begin
         r.status = STAT_RANGE;
      end else begin
         case (m)
            MODE_ACCESS: begin
               // first touch starts a fresh, pinned history
               if (!present[f]) begin
                  present[f]  = 1'b1;
                  evict_ok[f] = 1'b0;
                  hits[f]     = 0;
                  head[f]     = 0;
               end
               if (hits[f] < HIST) begin
                  hist[f][(head[f] + hits[f]) % HIST] = now_stamp;
                  hits[f]++;
               end else begin
                  hist[f][head[f]] = now_stamp;
                  head[f] = (head[f] + 1) % HIST;
               end
               now_stamp = now_stamp + stamp_type'(1);
            end
            MODE_MARK: begin
               if (!present[f]) begin
                  r.status = STAT_UNTRACKED;
               end else if (evict_ok[f] && !ev) begin
                  evict_ok[f] = 1'b0;
                  evict_total--;
               end else if (!evict_ok[f] && ev) begin
                  evict_ok[f] = 1'b1;
                  evict_total++;
               end
            end
            MODE_REMOVE: begin
               if (!present[f]) begin
                  r.status = STAT_UNTRACKED;
               end else if (!evict_ok[f]) begin
                  r.status = STAT_PINNED;
               end else begin
                  present[f]  = 1'b0;
                  evict_ok[f] = 1'b0;
                  evict_total--;
               end
            end
            default: begin
               // k clamps to 1..HIST; short histories rank as infinite
               k = (k_reg < 1) ? 1 : (k_reg > HIST) ? HIST : int'(k_reg);
               found    = 1'b0;
               best_inf = 1'b0;
               best_age = '0;
               best     = 0;
               for (int i = 0; i < FRAMES; i++) begin
                  if (present[i] && evict_ok[i]) begin
                     cnt  = hits[i];
                     inf  = (cnt < k);
                     slot = inf ? head[i] : (head[i] + cnt - k) % HIST;
                     age  = now_stamp - hist[i][slot];
                     if (!found || (inf && !best_inf) ||
                         (inf == best_inf && age > best_age)) begin
                        found    = 1'b1;
                        best_inf = inf;
                        best_age = age;
                        best     = i;
                     end
                  end
               end
               if (!found) begin
                  r.status = STAT_NO_VICTIM;
               end else begin
                  present[best]  = 1'b0;
                  evict_ok[best] = 1'b0;
                  evict_total--;
                  r.victim = victim_type'(best);
               end
            end
         endcase
      end
      r.count = count_type'(evict_total);
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         if (mismatches < 10)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // sample all three ports at each edge
   always @(posedge clock) begin : watch
      rsp_beat_type want;
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            present[i]  = 1'b0;
            evict_ok[i] = 1'b0;
            hits[i]     = 0;
            head[i]     = 0;
         end
         now_stamp   = '0;
         evict_total = 0;
         k_reg       = HIST_DEPTH_RESET;
         owed_rd     = 0;
         owed_wr     = 0;
         mismatches  = 0;
      end else begin
         if (csr_wr_en)
            k_reg = csr_wr_data;
         // responses first, so an early beat is never matched to its own request
         if (rsp_valid && !rsp_stall) begin
            if (owed_wr == owed_rd) begin
               if (mismatches < 10)
                  $display("response beat with nothing owed: status %0d victim %0d count %0d",
                           rsp_status, rsp_victim_frame, rsp_evictable_count);
               mismatches++;
            end else begin
               want = owed_buf[owed_rd % OWED_DEPTH];
               owed_rd++;
               check_field("status", 8'(want.status), 8'(rsp_status));
               check_field("victim_frame", 8'(want.victim), 8'(rsp_victim_frame));
               check_field("evictable_count", 8'(want.count), 8'(rsp_evictable_count));
            end
         end
         if (req_valid && !req_stall) begin
            if (owed_wr - owed_rd == OWED_DEPTH) begin
               if (mismatches < 10)
                  $display("too many responses owed: expected at most %0d, got %0d",
                           OWED_DEPTH - 1, OWED_DEPTH);
               mismatches++;
               owed_rd++;
            end
            owed_buf[owed_wr % OWED_DEPTH] = serve_request(req_mode, req_frame, req_evictable);
            owed_wr++;
         end
      end
      outstanding <= int'(owed_wr - owed_rd);
   end

endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb - regression bench for the LRU-K frame replacer
// Directed requests for the corner cases, then phases of random request
// sequences under varied history depth and handshake pressure. The checker
// beside the block predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
module tb;
   import lkr_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = DEF_FRAME_COUNT + 16;
   localparam int PHASE_BEATS  = 75;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   mode_type   req_mode = MODE_ACCESS;
   frame_type  req_frame = '0;
   logic       req_evictable = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   status_type rsp_status;
   victim_type rsp_victim_frame;
   count_type  rsp_evictable_count;
   logic       csr_wr_en = 1'b0;
   depth_type  csr_wr_data = '0;
   int         fail_count;
   int         outstanding;

   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         sent = 0;
   int         quiet = 0;

   always #1 clock = ~clock;

   lru_k_frame_replacer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_frame           (req_frame),
      .req_evictable       (req_evictable),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_victim_frame    (rsp_victim_frame),
      .rsp_evictable_count (rsp_evictable_count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   lru_k_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_frame           (req_frame),
      .req_evictable       (req_evictable),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_victim_frame    (rsp_victim_frame),
      .rsp_evictable_count (rsp_evictable_count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // one request beat, with an optional idle gap in front
   task automatic send_req(mode_type m, frame_type f, logic ev);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_frame     <= f;
      req_evictable <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // let every owed response arrive, then give the block time to settle
   task automatic settle();
      req_valid <= 1'b0;
      // the owed count is registered in the checker, so it lags the last beat
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_depth(depth_type d);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly a small hot set so histories grow deep; a few ids out of range
   function automatic frame_type pick_frame();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return frame_type'($urandom_range(0, 15));
      if (r < 95) return frame_type'($urandom_range(0, DEF_FRAME_COUNT - 1));
      return frame_type'($urandom_range(DEF_FRAME_COUNT, 255));
   endfunction

   // one random sequence: half the time an access run, mostly followed by a release
   task automatic random_sequence();
      int        pick;
      frame_type f;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         f = pick_frame();
         repeat ($urandom_range(1, 4)) send_req(MODE_ACCESS, f, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 99) < 75)
            send_req(MODE_MARK, f, 1'b1);
      end else if (pick < 70) begin
         send_req(MODE_EVICT, frame_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
         send_req(MODE_MARK, pick_frame(), 1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
         send_req(MODE_REMOVE, pick_frame(), 1'($urandom_range(0, 1)));
      end else begin
         send_req(mode_type'($urandom_range(0, 3)), frame_type'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      depth_type depths [8];
      int        start;
      depths = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd0};
      depths[7] = depth_type'($urandom_range(0, 15));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty evict, ids out of range, untracked and pinned frames
      send_req(MODE_EVICT, 8'd255, 1'b1);
      send_req(MODE_ACCESS, 8'd64, 1'b0);
      send_req(MODE_MARK, 8'd255, 1'b1);
      send_req(MODE_REMOVE, 8'd128, 1'b1);
      send_req(MODE_MARK, 8'd5, 1'b1);
      send_req(MODE_REMOVE, 8'd5, 1'b0);
      send_req(MODE_ACCESS, 8'd0, 1'b0);
      send_req(MODE_ACCESS, 8'd63, 1'b1);
      send_req(MODE_ACCESS, 8'd0, 1'b0);
      send_req(MODE_REMOVE, 8'd0, 1'b0);
      // infinite distance wins over a full history
      send_req(MODE_MARK, 8'd0, 1'b1);
      send_req(MODE_MARK, 8'd63, 1'b1);
      send_req(MODE_MARK, 8'd63, 1'b1);
      send_req(MODE_EVICT, 8'd0, 1'b0);
      // re-tracked frame comes back pinned; clearing and restoring a mark
      send_req(MODE_ACCESS, 8'd63, 1'b0);
      send_req(MODE_MARK, 8'd63, 1'b0);
      send_req(MODE_MARK, 8'd0, 1'b0);
      send_req(MODE_MARK, 8'd0, 1'b1);
      send_req(MODE_REMOVE, 8'd0, 1'b1);
      // two full histories: the older k-th access goes first
      send_req(MODE_ACCESS, 8'd1, 1'b0);
      send_req(MODE_ACCESS, 8'd2, 1'b0);
      send_req(MODE_ACCESS, 8'd1, 1'b0);
      send_req(MODE_ACCESS, 8'd2, 1'b0);
      send_req(MODE_MARK, 8'd1, 1'b1);
      send_req(MODE_MARK, 8'd2, 1'b1);
      send_req(MODE_EVICT, 8'd0, 1'b0);
      send_req(MODE_EVICT, 8'd0, 1'b0);
      send_req(MODE_EVICT, 8'd0, 1'b0);

      // random phases: each with its own depth and handshake pressure
      for (int p = 0; p < 8; p++) begin
         settle();
         write_depth(depths[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 67; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         // one phase fills the whole table and makes every frame evictable
         if (p == 2) begin
            for (int f = 0; f < DEF_FRAME_COUNT; f++)
               send_req(MODE_ACCESS, frame_type'(f), 1'b0);
            for (int f = 0; f < DEF_FRAME_COUNT; f++)
               send_req(MODE_MARK, frame_type'(f), 1'b1);
         end
         start = sent;
         while (sent - start < PHASE_BEATS) random_sequence();
      end

      settle();
      if (fail_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire

// File: lru_k_frame_replacer.f
rtl/lkr_pkg.sv
rtl/lkr_hist.sv
rtl/lru_k_frame_replacer.sv
dv/lru_k_checker.sv
dv/tb.sv
